/* rtl/csim_pkg.sv */
`default_nettype none

package csim_pkg;

    localparam int ELEM_W     = 16;   // port width of one element
    localparam int NORM_W     = 40;   // squared-norm accumulators
    localparam int DOT_W      = 41;   // signed dot-product accumulator
    localparam int PROD_W     = 80;   // 40 x 40 product
    localparam int CAND_W     = 116;  // candidate s^2 * na * nb during the search
    localparam int SIM_W      = 17;   // unsigned Q1.16 result
    localparam int SEARCH_TOP = 16;   // top result bit, 1.0 in Q1.16
    localparam int DIGIT_W    = 8;    // multiplier digit per cycle
    localparam int MUL_STEPS  = 5;    // NORM_W / DIGIT_W digits
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [DOT_W-1:0]  dot;
        logic [NORM_W-1:0] norm_a;
        logic [NORM_W-1:0] norm_b;
        logic              bad;
        logic              dot_pos;
    } snap_t;

endpackage

`default_nettype wire

/* rtl/csim_front.sv */
`default_nettype none

module csim_front #(
    parameter int ELEM_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [csim_pkg::ELEM_W-1:0]   elem_a,
    input  wire logic [csim_pkg::ELEM_W-1:0]   elem_b,
    input  wire logic                          a_present,
    input  wire logic                          b_present,
    input  wire logic                          last,
    output logic                               push,
    output csim_pkg::snap_t                    push_data,
    input  wire logic                          full
);

    localparam int PW = 2 * ELEM_BITS;
    localparam int NW = csim_pkg::NORM_W;
    localparam int DW = csim_pkg::DOT_W;
    localparam int SW = ((PW > DW) ? PW : DW) + 1;

    logic [ELEM_BITS-1:0] raw_a;
    logic [ELEM_BITS-1:0] raw_b;
    logic signed [ELEM_BITS-1:0] ea;
    logic signed [ELEM_BITS-1:0] eb;

    generate
        if (ELEM_BITS <= csim_pkg::ELEM_W) begin : g_narrow
            assign raw_a = elem_a[ELEM_BITS-1:0];
            assign raw_b = elem_b[ELEM_BITS-1:0];
        end else begin : g_wide
            assign raw_a = {{(ELEM_BITS-csim_pkg::ELEM_W){1'b0}}, elem_a};
            assign raw_b = {{(ELEM_BITS-csim_pkg::ELEM_W){1'b0}}, elem_b};
        end
    endgenerate

    assign ea = $signed(raw_a);
    assign eb = $signed(raw_b);

    // product stage
    logic                 s1_valid_reg;
    logic                 s1_both_reg;
    logic                 s1_one_reg;
    logic                 s1_last_reg;
    logic [PW-1:0]        prod_aa_reg;
    logic [PW-1:0]        prod_bb_reg;
    logic signed [PW-1:0] prod_ab_reg;

    // accumulator stage
    logic [NW-1:0] norm_a_reg, norm_a_next;
    logic [NW-1:0] norm_b_reg, norm_b_next;
    logic [DW-1:0] dot_reg, dot_next;
    logic          mismatch_reg, mismatch_next;
    logic          pair_reg, pair_next;

    logic [SW-1:0] na_wide, nb_wide, dot_wide;
    logic [NW-1:0] na_upd, nb_upd;
    logic [DW-1:0] dot_upd;
    logic          mismatch_upd, pair_upd;
    logic          blocked;
    logic [SW-DW:0] dot_top;

    assign blocked  = s1_valid_reg && s1_last_reg && full;
    assign in_ready = !blocked;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_both_reg <= a_present && b_present;
            s1_one_reg  <= a_present ^ b_present;
            s1_last_reg <= last;
            prod_aa_reg <= PW'(ea * ea);
            prod_bb_reg <= PW'(eb * eb);
            prod_ab_reg <= PW'(ea * eb);
        end
    end

    always_comb
    begin
        na_wide  = SW'(norm_a_reg) + SW'(prod_aa_reg);
        nb_wide  = SW'(norm_b_reg) + SW'(prod_bb_reg);
        dot_wide = {{(SW-DW){dot_reg[DW-1]}}, dot_reg}
                 + {{(SW-PW){prod_ab_reg[PW-1]}}, prod_ab_reg};
        dot_top  = dot_wide[SW-1:DW-1];

        na_upd       = norm_a_reg;
        nb_upd       = norm_b_reg;
        dot_upd      = dot_reg;
        mismatch_upd = mismatch_reg;
        pair_upd     = pair_reg;

        if (s1_both_reg)
        begin
            // saturate norms at all ones, dot within its signed range
            na_upd = (|na_wide[SW-1:NW]) ? {NW{1'b1}} : na_wide[NW-1:0];
            nb_upd = (|nb_wide[SW-1:NW]) ? {NW{1'b1}} : nb_wide[NW-1:0];
            if ((&dot_top) || !(|dot_top))
                dot_upd = dot_wide[DW-1:0];
            else if (dot_wide[SW-1])
                dot_upd = {1'b1, {(DW-1){1'b0}}};
            else
                dot_upd = {1'b0, {(DW-1){1'b1}}};
            pair_upd = 1'b1;
        end
        else if (s1_one_reg)
        begin
            mismatch_upd = 1'b1;
        end

        push_data.dot     = dot_upd;
        push_data.norm_a  = na_upd;
        push_data.norm_b  = nb_upd;
        push_data.bad     = !pair_upd || mismatch_upd || (na_upd == '0) || (nb_upd == '0);
        push_data.dot_pos = !dot_upd[DW-1] && (dot_upd != '0);

        push = s1_valid_reg && s1_last_reg && !full;

        norm_a_next   = norm_a_reg;
        norm_b_next   = norm_b_reg;
        dot_next      = dot_reg;
        mismatch_next = mismatch_reg;
        pair_next     = pair_reg;
        if (s1_valid_reg && !blocked)
        begin
            if (s1_last_reg)
            begin
                norm_a_next   = '0;
                norm_b_next   = '0;
                dot_next      = '0;
                mismatch_next = 1'b0;
                pair_next     = 1'b0;
            end
            else
            begin
                norm_a_next   = na_upd;
                norm_b_next   = nb_upd;
                dot_next      = dot_upd;
                mismatch_next = mismatch_upd;
                pair_next     = pair_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_a_reg   <= '0;
            norm_b_reg   <= '0;
            dot_reg      <= '0;
            mismatch_reg <= 1'b0;
            pair_reg     <= 1'b0;
        end
        else
        begin
            norm_a_reg   <= norm_a_next;
            norm_b_reg   <= norm_b_next;
            dot_reg      <= dot_next;
            mismatch_reg <= mismatch_next;
            pair_reg     <= pair_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/csim_queue.sv */
`default_nettype none

module csim_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire csim_pkg::snap_t push_data,
    input  wire logic            pop,
    output csim_pkg::snap_t      pop_data,
    output logic                 full,
    output logic                 empty
);

    localparam int D  = csim_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (D > 1) ? $clog2(D) : 1;
    localparam int CNT_W = $clog2(D + 1);

    csim_pkg::snap_t          entry_reg [D];
    logic [PTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    assign full     = (count_reg == CNT_W'(D));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(D - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(D - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/csim_back.sv */
`default_nettype none

module csim_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire csim_pkg::snap_t              q_data,
    input  wire logic                         q_empty,
    output logic                              pop,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [csim_pkg::SIM_W-1:0]        similarity,
    output logic                              invalid
);

    localparam int NW = csim_pkg::NORM_W;
    localparam int PW = csim_pkg::PROD_W;
    localparam int CW = csim_pkg::CAND_W;
    localparam int SW = csim_pkg::SIM_W;
    localparam int GW = csim_pkg::DIGIT_W;
    localparam int KW = $clog2(csim_pkg::SEARCH_TOP + 1);
    localparam int MCW = $clog2(csim_pkg::MUL_STEPS);
    localparam int FRAC = 2 * csim_pkg::SEARCH_TOP;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_T,
        ST_ADD,
        ST_CMP,
        ST_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [PW-1:0]    mul_a_reg, mul_a_next;
    logic [NW-1:0]    mul_b_reg, mul_b_next;
    logic [PW-1:0]    mul_acc_reg, mul_acc_next;
    logic [MCW-1:0]   mul_cnt_reg, mul_cnt_next;
    logic [NW-1:0]    dot_hold_reg, dot_hold_next;
    logic [CW-1:0]    t_reg, t_next;        // dot^2 * 2^32
    logic [CW-1:0]    q_reg, q_next;        // s^2 * na * nb
    logic [CW-1:0]    rs_reg, rs_next;      // s * na * nb shifted to the current bit
    logic [CW-1:0]    pk_reg, pk_next;      // na * nb shifted to twice the current bit
    logic [CW-1:0]    cand_reg, cand_next;
    logic [SW-1:0]    s_reg, s_next;
    logic [KW-1:0]    k_reg, k_next;
    logic             bad_reg, bad_next;
    logic             out_valid_reg, out_valid_next;
    logic [SW-1:0]    out_sim_reg, out_sim_next;
    logic             out_bad_reg, out_bad_next;

    logic [PW-1:0]    mul_term;
    logic [PW-1:0]    mul_sum;
    logic             fits;
    logic [CW-1:0]    rs_acc;

    assign out_valid  = out_valid_reg;
    assign similarity = out_sim_reg;
    assign invalid    = out_bad_reg;

    always_comb
    begin
        mul_term = mul_a_reg * PW'(mul_b_reg[GW-1:0]);
        mul_sum  = mul_acc_reg + mul_term;
        fits     = (cand_reg <= t_reg);
        rs_acc   = rs_reg + (fits ? (pk_reg << 1) : '0);

        state_next     = state_reg;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        mul_acc_next   = mul_acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        dot_hold_next  = dot_hold_reg;
        t_next         = t_reg;
        q_next         = q_reg;
        rs_next        = rs_reg;
        pk_next        = pk_reg;
        cand_next      = cand_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg;
        out_sim_next   = out_sim_reg;
        out_bad_next   = out_bad_reg;
        pop            = 1'b0;

        if (out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop      = 1'b1;
                    bad_next = q_data.bad;
                    s_next   = '0;
                    if (q_data.bad || !q_data.dot_pos)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mul_a_next    = PW'(q_data.norm_a);
                        mul_b_next    = q_data.norm_b;
                        mul_acc_next  = '0;
                        mul_cnt_next  = '0;
                        dot_hold_next = q_data.dot[NW-1:0];
                        state_next    = ST_MUL_P;
                    end
                end
            end

            ST_MUL_P, ST_MUL_T:
            begin
                mul_acc_next = mul_sum;
                mul_a_next   = mul_a_reg << GW;
                mul_b_next   = mul_b_reg >> GW;
                mul_cnt_next = mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == MCW'(csim_pkg::MUL_STEPS - 1))
                begin
                    mul_acc_next = '0;
                    mul_cnt_next = '0;
                    if (state_reg == ST_MUL_P)
                    begin
                        pk_next    = {{(CW-PW-FRAC){1'b0}}, mul_sum, {FRAC{1'b0}}};
                        mul_a_next = PW'(dot_hold_reg);
                        mul_b_next = dot_hold_reg;
                        state_next = ST_MUL_T;
                    end
                    else
                    begin
                        t_next     = {{(CW-PW-FRAC){1'b0}}, mul_sum, {FRAC{1'b0}}};
                        q_next     = '0;
                        rs_next    = '0;
                        k_next     = KW'(csim_pkg::SEARCH_TOP);
                        state_next = ST_ADD;
                    end
                end
            end

            ST_ADD:
            begin
                cand_next  = q_reg + rs_reg + pk_reg;
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (fits)
                begin
                    q_next = cand_reg;
                    s_next = s_reg | (SW'(1) << k_reg);
                end
                // 1.0 fits: nothing above it may be tried
                if ((k_reg == '0) || (fits && (k_reg == KW'(csim_pkg::SEARCH_TOP))))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rs_next    = rs_acc >> 1;
                    pk_next    = pk_reg >> 2;
                    k_next     = k_reg - 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_sim_next   = s_reg;
                    out_bad_next   = bad_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_acc_reg   <= '0;
            mul_cnt_reg   <= '0;
            dot_hold_reg  <= '0;
            t_reg         <= '0;
            q_reg         <= '0;
            rs_reg        <= '0;
            pk_reg        <= '0;
            cand_reg      <= '0;
            s_reg         <= '0;
            k_reg         <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sim_reg   <= '0;
            out_bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_a_reg     <= mul_a_next;
            mul_b_reg     <= mul_b_next;
            mul_acc_reg   <= mul_acc_next;
            mul_cnt_reg   <= mul_cnt_next;
            dot_hold_reg  <= dot_hold_next;
            t_reg         <= t_next;
            q_reg         <= q_next;
            rs_reg        <= rs_next;
            pk_reg        <= pk_next;
            cand_reg      <= cand_next;
            s_reg         <= s_next;
            k_reg         <= k_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            out_sim_reg   <= out_sim_next;
            out_bad_reg   <= out_bad_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cosine_similarity_engine_core.sv */
// Throughput: one element pair per cycle; input stalls only while a last item waits for room.
// The back end handles one result at a time; an invalid or non-positive result skips the
// two products and the 17-step bit search (an add and a compare per step), which a valid
// result passes through; the search stops early when the result is exactly 1.0. The
// two-entry queue absorbs pending results.
// Reset: asynchronous, active low; clears sums, queue and result register.
`default_nettype none

module cosine_similarity_engine_core #(
    parameter int ELEM_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [csim_pkg::ELEM_W-1:0] elem_a,
    input  wire logic [csim_pkg::ELEM_W-1:0] elem_b,
    input  wire logic                        a_present,
    input  wire logic                        b_present,
    input  wire logic                        last,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [csim_pkg::SIM_W-1:0]       similarity,
    output logic                             invalid
);

    csim_pkg::snap_t push_data;
    csim_pkg::snap_t pop_data;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;

    csim_front #(
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .elem_a    (elem_a),
        .elem_b    (elem_b),
        .a_present (a_present),
        .b_present (b_present),
        .last      (last),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full)
    );

    csim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    csim_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (pop_data),
        .q_empty    (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .similarity (similarity),
        .invalid    (invalid)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_full)
        else $error("input stalled with room in queue");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && invalid) |-> (similarity == '0))
        else $error("invalid result with nonzero similarity");

    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (similarity <= csim_pkg::SIM_W'(1 << csim_pkg::SEARCH_TOP)))
        else $error("similarity above 1.0");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam longint NORM_MAX     = 64'sh00FF_FFFF_FFFF;
    localparam longint DOT_MAX      = 64'sh00FF_FFFF_FFFF;
    localparam longint DOT_MIN      = -64'sh0100_0000_0000;
    localparam int     ONE_Q16      = 65536;
    localparam int     RANDOM_ITEMS = 200;
    localparam int     SAT_LEN      = 1030;
    localparam int     DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [csim_pkg::ELEM_W-1:0] elem_a;
        logic [csim_pkg::ELEM_W-1:0] elem_b;
        logic                        a_present;
        logic                        b_present;
        logic                        last;
    } pair_item_t;

    typedef struct packed {
        logic [csim_pkg::SIM_W-1:0] similarity;
        logic                       invalid;
    } score_t;

    typedef enum int { VAL_FULL, VAL_SMALL, VAL_EDGE } value_style_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic [csim_pkg::ELEM_W-1:0] elem_a = '0;
    logic [csim_pkg::ELEM_W-1:0] elem_b = '0;
    logic                        a_present = 1'b0;
    logic                        b_present = 1'b0;
    logic                        last = 1'b0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [csim_pkg::SIM_W-1:0]  similarity;
    logic                        invalid;

    pair_item_t pending_pairs[$];
    score_t     expected_scores[$];
    pair_item_t next_pair;
    pair_item_t seen_pair;
    score_t     want;

    int accepted_pairs = 0;
    int phase_len = 1;
    int fail_count = 0;

    // running sums of the comparison in progress
    longint acc_norm_a = 0;
    longint acc_norm_b = 0;
    longint acc_dot = 0;
    bit     mismatch_seen = 1'b0;
    bit     pair_seen = 1'b0;

    cosine_similarity_engine_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elem_a     (elem_a),
        .elem_b     (elem_b),
        .a_present  (a_present),
        .b_present  (b_present),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .similarity (similarity),
        .invalid    (invalid)
    );

    always #5 clk = ~clk;

    // largest s in 0..1.0 with s^2 * na * nb <= dot^2 * 2^32
    function automatic int clamped_cosine(input longint dot, input longint na, input longint nb);
        logic [127:0] target;
        logic [127:0] lhs;
        logic [127:0] sq;
        int lo;
        int hi;
        int mid;
        target = (128'(dot) * 128'(dot)) << 32;
        lo = 0;
        hi = ONE_Q16;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            sq = 128'(mid);
            lhs = sq * sq * 128'(na) * 128'(nb);
            if (lhs <= target)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic predict_pair(input pair_item_t it);
        longint av;
        longint bv;
        longint d;
        score_t sc;
        bit     bad;
        if (it.a_present && it.b_present)
        begin
            av = longint'($signed(it.elem_a));
            bv = longint'($signed(it.elem_b));
            acc_norm_a = (acc_norm_a + av * av > NORM_MAX) ? NORM_MAX : acc_norm_a + av * av;
            acc_norm_b = (acc_norm_b + bv * bv > NORM_MAX) ? NORM_MAX : acc_norm_b + bv * bv;
            d = acc_dot + av * bv;
            if (d > DOT_MAX)
                d = DOT_MAX;
            if (d < DOT_MIN)
                d = DOT_MIN;
            acc_dot = d;
            pair_seen = 1'b1;
        end
        else if (it.a_present != it.b_present)
        begin
            mismatch_seen = 1'b1;
        end
        if (it.last)
        begin
            bad = !pair_seen || mismatch_seen || acc_norm_a == 0 || acc_norm_b == 0;
            sc.similarity = (!bad && acc_dot > 0) ?
                csim_pkg::SIM_W'(clamped_cosine(acc_dot, acc_norm_a, acc_norm_b)) : '0;
            sc.invalid = bad;
            expected_scores.insert(expected_scores.size(), sc);
            acc_norm_a = 0;
            acc_norm_b = 0;
            acc_dot = 0;
            mismatch_seen = 1'b0;
            pair_seen = 1'b0;
        end
    endtask

    function automatic void queue_pair(input int a, input int b, input bit ap, input bit bp,
                                       input bit lst);
        pair_item_t it;
        it.elem_a = csim_pkg::ELEM_W'(a);
        it.elem_b = csim_pkg::ELEM_W'(b);
        it.a_present = ap;
        it.b_present = bp;
        it.last = lst;
        pending_pairs.insert(pending_pairs.size(), it);
    endfunction

    function automatic logic [csim_pkg::ELEM_W-1:0] pick_elem(input value_style_t style);
        int v;
        case (style)
            VAL_FULL:  v = int'($urandom_range(0, 65535));
            VAL_SMALL: v = int'($urandom_range(0, 511)) - 256;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       v = 32767;
                    1:       v = -32768;
                    2:       v = 1;
                    3:       v = -1;
                    default: v = 0;
                endcase
            end
        endcase
        return csim_pkg::ELEM_W'(v);
    endfunction

    // relation: 0 independent, 1 near copy, 2 near negation, 3 half scale
    function automatic logic [csim_pkg::ELEM_W-1:0] partner_elem(
        input logic [csim_pkg::ELEM_W-1:0] a,
        input int                          relation,
        input value_style_t                style);
        int av;
        int v;
        av = int'($signed(a));
        case (relation)
            0:       v = int'($signed(pick_elem(style)));
            1:       v = av + int'($urandom_range(0, 64)) - 32;
            2:       v = -av + int'($urandom_range(0, 64)) - 32;
            default: v = av >>> 1;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return csim_pkg::ELEM_W'(v);
    endfunction

    function automatic int idle_pct(input bit receiver);
        int ph;
        ph = accepted_pairs / phase_len;
        if (ph == 0)
            return receiver ? 60 : 11;
        if (ph == 1)
            return receiver ? 11 : 60;
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
            begin
                next_pair = pending_pairs[0];
                pending_pairs.delete(0);
                in_valid  <= 1'b1;
                elem_a    <= next_pair.elem_a;
                elem_b    <= next_pair.elem_b;
                a_present <= next_pair.a_present;
                b_present <= next_pair.b_present;
                last      <= next_pair.last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                seen_pair.elem_a = elem_a;
                seen_pair.elem_b = elem_b;
                seen_pair.a_present = a_present;
                seen_pair.b_present = b_present;
                seen_pair.last = last;
                predict_pair(seen_pair);
                accepted_pairs <= accepted_pairs + 1;
            end
            if (out_valid && out_ready)
            begin
                if (expected_scores.size() == 0)
                begin
                    $error("unexpected result: similarity %0d invalid %0b", similarity, invalid);
                    fail_count++;
                end
                else
                begin
                    want = expected_scores[0];
                    expected_scores.delete(0);
                    if (similarity !== want.similarity)
                    begin
                        $error("similarity: expected %0d, got %0d", want.similarity, similarity);
                        fail_count++;
                    end
                    if (invalid !== want.invalid)
                    begin
                        $error("invalid: expected %0b, got %0b", want.invalid, invalid);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int len;
        int flavor;
        int relation;
        int odd_pos;
        int zero_side;
        int k;
        int random_count;
        value_style_t style;
        logic [csim_pkg::ELEM_W-1:0] a;
        logic [csim_pkg::ELEM_W-1:0] b;
        bit ap;
        bit bp;
        bit lst;

        // extremes and one-item comparisons
        queue_pair(32767, 32767, 1, 1, 1);
        queue_pair(-32768, -32768, 1, 1, 1);
        queue_pair(-32768, 32767, 1, 1, 1);
        // empty comparisons, with junk data on absent elements
        queue_pair(0, 0, 0, 0, 1);
        queue_pair(-1, 12345, 0, 0, 0);
        queue_pair(77, -77, 0, 0, 1);
        // one side longer than the other
        queue_pair(100, 0, 1, 0, 0);
        queue_pair(5, 5, 1, 1, 1);
        queue_pair(0, -300, 0, 1, 0);
        queue_pair(5, 5, 1, 1, 1);
        // zero norms
        queue_pair(0, 9, 1, 1, 0);
        queue_pair(0, -3, 1, 1, 1);
        queue_pair(0, 0, 1, 1, 1);
        // orthogonal: zero dot, still valid
        queue_pair(1, 0, 1, 1, 0);
        queue_pair(0, 1, 1, 1, 1);
        // bubble inside a comparison
        queue_pair(3, 4, 1, 1, 0);
        queue_pair(-21555, -32768, 0, 0, 0);
        queue_pair(4, 3, 1, 1, 1);
        queue_pair(1, 1, 1, 1, 0);
        queue_pair(1, -1, 1, 1, 0);
        queue_pair(2, 2, 1, 1, 1);
        // bubble carries the last mark
        queue_pair(-32768, 1, 1, 1, 0);
        queue_pair(-5, 6, 0, 0, 1);

        // long vector that drives every sum into saturation
        for (k = 0; k < SAT_LEN; k++)
            queue_pair(-32768, -32768, 1, 1, k == SAT_LEN - 1);

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
            style = value_style_t'($urandom_range(0, 2));
            relation = $urandom_range(0, 3);
            flavor = $urandom_range(0, 99);
            odd_pos = $urandom_range(0, len - 1);
            zero_side = $urandom_range(0, 1);
            for (k = 0; k < len; k++)
            begin
                a = pick_elem(style);
                b = partner_elem(a, relation, style);
                ap = 1'b1;
                bp = 1'b1;
                lst = (k == len - 1);
                if (flavor >= 97)
                begin
                    if (zero_side)
                        a = '0;
                    else
                        b = '0;
                end
                if (flavor >= 85 && flavor < 93 && k == odd_pos)
                begin
                    ap = 1'($urandom_range(0, 1));
                    bp = !ap;
                end
                else if ((flavor >= 93 && flavor < 97) || $urandom_range(0, 19) == 0)
                begin
                    ap = 1'b0;
                    bp = 1'b0;
                end
                queue_pair(a, b, ap, bp, lst);
                if (ap || bp || lst)
                    random_count++;
            end
        end

        phase_len = (pending_pairs.size() + 2) / 3;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
